@@ sv/calendar_to_epoch_timestamp_unit_defines.svh @@
// Assertion macros shared by the timestamp unit RTL.
`ifndef CALENDAR_TO_EPOCH_TIMESTAMP_UNIT_DEFINES_SVH
`define CALENDAR_TO_EPOCH_TIMESTAMP_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CTE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timestamp unit assertion failed");

// Consequent checked in the cycle after the antecedent.
`define CTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timestamp unit assertion failed");

`endif

@@ sv/cte_pkg.sv @@
package cte_pkg;

   // Field and register widths
   localparam int YEAR_W   = 7;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int ZONE_W   = 11;
   localparam int TS_W     = 42;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Shared multiply-accumulate widths
   localparam int COUNT_W = 11;
   localparam int SCALE_W = 27;
   localparam int PROD_W  = COUNT_W + SCALE_W;

   // Year index counts from 1970; 2000 sits 30 years in
   localparam int YIDX_W = 8;
   localparam logic [YIDX_W-1:0] YEAR_BASE_OFFSET = 8'd30;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_MILLIS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_OFFSET = 2'd1;

   // Unit constants
   localparam logic [SCALE_W-1:0] DAY_MS    = 27'd86400000;
   localparam logic [SCALE_W-1:0] DAY_S     = 27'd86400;
   localparam logic [SCALE_W-1:0] HOUR_MS   = 27'd3600000;
   localparam logic [SCALE_W-1:0] HOUR_S    = 27'd3600;
   localparam logic [SCALE_W-1:0] MINUTE_MS = 27'd60000;
   localparam logic [SCALE_W-1:0] MINUTE_S  = 27'd60;
   localparam logic [SCALE_W-1:0] SECOND_MS = 27'd1000;
   localparam logic [SCALE_W-1:0] SECOND_S  = 27'd1;

   localparam logic [COUNT_W-1:0] DAYS_LEAP   = 11'd366;
   localparam logic [COUNT_W-1:0] DAYS_COMMON = 11'd365;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YEAR,
      ST_MONTH,
      ST_DAY,
      ST_HOUR,
      ST_MINUTE,
      ST_SECOND,
      ST_ZONE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SCALE_DAY,
      SCALE_HOUR,
      SCALE_MINUTE,
      SCALE_SECOND
   } scale_sel_type;

   // Sequencer to accumulator
   typedef struct packed {
      logic                clear;
      logic                add_en;
      logic                subtract;
      scale_sel_type       scale_sel;
      logic [COUNT_W-1:0]  count;
   } alu_ctrl_type;

   // Sequencer to top level
   typedef struct packed {
      logic req_ready;
      logic load_out;
      logic field_error;
   } seq_status_type;

   // Days in a month; zero for codes that name no month
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (mo)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // Scale factor for one step, seconds or milliseconds
   function automatic logic [SCALE_W-1:0] scale_of(input scale_sel_type sel,
                                                   input logic millis);
      logic [SCALE_W-1:0] s;
      unique case (sel)
         SCALE_DAY:    s = millis ? DAY_MS    : DAY_S;
         SCALE_HOUR:   s = millis ? HOUR_MS   : HOUR_S;
         SCALE_MINUTE: s = millis ? MINUTE_MS : MINUTE_S;
         SCALE_SECOND: s = millis ? SECOND_MS : SECOND_S;
         default:      s = '0;
      endcase
      return s;
   endfunction

endpackage

@@ sv/cte_ifs.sv @@
interface cte_req_if;
   logic                          valid;
   logic                          ready;
   logic [cte_pkg::YEAR_W-1:0]    year_of_century;
   logic [cte_pkg::MONTH_W-1:0]   month_number;
   logic [cte_pkg::DAY_W-1:0]     day_of_month;
   logic [cte_pkg::HOUR_W-1:0]    hour_of_day;
   logic [cte_pkg::MINUTE_W-1:0]  minute_of_hour;
   logic [cte_pkg::SECOND_W-1:0]  second_of_minute;

   modport source (output valid, year_of_century, month_number, day_of_month,
                   hour_of_day, minute_of_hour, second_of_minute, input ready);
   modport sink   (input valid, year_of_century, month_number, day_of_month,
                   hour_of_day, minute_of_hour, second_of_minute, output ready);
endinterface

interface cte_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [cte_pkg::TS_W-1:0]  timestamp;
   logic                      field_error;

   modport source (output valid, timestamp, field_error, input ready);
   modport sink   (input valid, timestamp, field_error, output ready);
endinterface

interface cte_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cte_pkg::CSR_IDX_W-1:0]   index;
   logic [cte_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/cte_alu.sv @@
// Shared multiply-accumulate: acc +/- count * scale, product registered
module cte_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  cte_pkg::alu_ctrl_type       ctrl,
   input  logic                        unit_millis,
   output logic [cte_pkg::TS_W-1:0]    acc
);

   logic [cte_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                       add_en_ff, add_en_in;
   logic                       sub_ff, sub_in;
   logic [cte_pkg::TS_W-1:0]   acc_ff, acc_in;

   // Stage 1: product of step count and unit scale
   always_comb begin
      prod_in   = cte_pkg::PROD_W'(ctrl.count) *
                  cte_pkg::PROD_W'(cte_pkg::scale_of(ctrl.scale_sel, unit_millis));
      add_en_in = ctrl.add_en && !ctrl.clear;
      sub_in    = ctrl.subtract;
   end

   // Stage 2: accumulate, wrapping at 42 bits
   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (add_en_ff) begin
         acc_in = sub_ff ? acc_ff - cte_pkg::TS_W'(prod_ff)
                         : acc_ff + cte_pkg::TS_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         add_en_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         add_en_ff <= add_en_in;
         acc_ff    <= acc_in;
      end
      prod_ff <= prod_in;
      sub_ff  <= sub_in;
   end

   assign acc = acc_ff;

endmodule

@@ sv/cte_seq.sv @@
// Step sequencer: years, months, then day, hour, minute, second and zone
module cte_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [cte_pkg::YEAR_W-1:0]      year_of_century,
   input  logic [cte_pkg::MONTH_W-1:0]     month_number,
   input  logic [cte_pkg::DAY_W-1:0]       day_of_month,
   input  logic [cte_pkg::HOUR_W-1:0]      hour_of_day,
   input  logic [cte_pkg::MINUTE_W-1:0]    minute_of_hour,
   input  logic [cte_pkg::SECOND_W-1:0]    second_of_minute,
   input  logic [cte_pkg::ZONE_W-1:0]      zone_offset,
   input  logic                            out_free,
   output cte_pkg::alu_ctrl_type           ctrl,
   output cte_pkg::seq_status_type         status
);

   cte_pkg::state_type state_ff, state_in;

   logic [cte_pkg::YEAR_W-1:0]    year_ff;
   logic [cte_pkg::MONTH_W-1:0]   month_ff;
   logic [cte_pkg::DAY_W-1:0]     day_ff;
   logic [cte_pkg::HOUR_W-1:0]    hour_ff;
   logic [cte_pkg::MINUTE_W-1:0]  minute_ff;
   logic [cte_pkg::SECOND_W-1:0]  second_ff;
   logic                          err_ff, err_in;
   logic [cte_pkg::YIDX_W-1:0]    yidx_ff, yidx_in;
   logic [cte_pkg::MONTH_W-1:0]   midx_ff, midx_in;

   logic                          accept;
   logic                          in_leap;
   logic                          in_bad;
   logic                          target_leap;
   logic [cte_pkg::YIDX_W-1:0]    year_target;
   logic                          year_more;
   logic                          month_more;

   // Range check on the incoming transaction
   always_comb begin
      accept  = req_valid && (state_ff == cte_pkg::ST_IDLE);
      in_leap = (year_of_century[1:0] == 2'd0);
      in_bad  = (year_of_century > 7'd99) || (month_number == 4'd0) ||
                (month_number > 4'd12) || (day_of_month == 5'd0) ||
                (day_of_month > cte_pkg::month_len(month_number, in_leap)) ||
                (hour_of_day > 5'd23) || (minute_of_hour > 6'd59) ||
                (second_of_minute > 6'd59);
   end

   // Loop bounds; years between 1970 and 2099 are leap when divisible by four
   always_comb begin
      target_leap = (year_ff[1:0] == 2'd0);
      year_target = cte_pkg::YIDX_W'(year_ff) + cte_pkg::YEAR_BASE_OFFSET;
      year_more   = (yidx_ff != year_target);
      month_more  = (midx_ff != month_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cte_pkg::ST_IDLE:   if (accept) begin
                                state_in = in_bad ? cte_pkg::ST_FINISH : cte_pkg::ST_YEAR;
                             end
         cte_pkg::ST_YEAR:   if (!year_more) begin
                                state_in = cte_pkg::ST_MONTH;
                             end
         cte_pkg::ST_MONTH:  if (!month_more) begin
                                state_in = cte_pkg::ST_DAY;
                             end
         cte_pkg::ST_DAY:    state_in = cte_pkg::ST_HOUR;
         cte_pkg::ST_HOUR:   state_in = cte_pkg::ST_MINUTE;
         cte_pkg::ST_MINUTE: state_in = cte_pkg::ST_SECOND;
         cte_pkg::ST_SECOND: state_in = cte_pkg::ST_ZONE;
         cte_pkg::ST_ZONE:   state_in = cte_pkg::ST_DRAIN;
         cte_pkg::ST_DRAIN:  state_in = cte_pkg::ST_FINISH;
         cte_pkg::ST_FINISH: if (out_free) begin
                                state_in = cte_pkg::ST_IDLE;
                             end
         default:            state_in = cte_pkg::ST_IDLE;
      endcase
   end

   // Step controls for the shared unit
   always_comb begin
      ctrl             = '0;
      ctrl.scale_sel   = cte_pkg::SCALE_DAY;
      status           = '0;
      status.field_error = err_ff;
      unique case (state_ff)
         cte_pkg::ST_IDLE: begin
            status.req_ready = 1'b1;
            ctrl.clear       = accept;
         end
         cte_pkg::ST_YEAR: begin
            ctrl.add_en = year_more;
            ctrl.count  = (yidx_ff[1:0] == 2'd2) ? cte_pkg::DAYS_LEAP
                                                 : cte_pkg::DAYS_COMMON;
         end
         cte_pkg::ST_MONTH: begin
            ctrl.add_en = month_more;
            ctrl.count  = cte_pkg::COUNT_W'(cte_pkg::month_len(midx_ff, target_leap));
         end
         cte_pkg::ST_DAY: begin
            ctrl.add_en = 1'b1;
            ctrl.count  = cte_pkg::COUNT_W'(day_ff - 5'd1);
         end
         cte_pkg::ST_HOUR: begin
            ctrl.add_en    = 1'b1;
            ctrl.scale_sel = cte_pkg::SCALE_HOUR;
            ctrl.count     = cte_pkg::COUNT_W'(hour_ff);
         end
         cte_pkg::ST_MINUTE: begin
            ctrl.add_en    = 1'b1;
            ctrl.scale_sel = cte_pkg::SCALE_MINUTE;
            ctrl.count     = cte_pkg::COUNT_W'(minute_ff);
         end
         cte_pkg::ST_SECOND: begin
            ctrl.add_en    = 1'b1;
            ctrl.scale_sel = cte_pkg::SCALE_SECOND;
            ctrl.count     = cte_pkg::COUNT_W'(second_ff);
         end
         cte_pkg::ST_ZONE: begin
            // Zone ahead of UTC is subtracted; magnitude of -1024 still fits
            ctrl.add_en    = 1'b1;
            ctrl.scale_sel = cte_pkg::SCALE_MINUTE;
            ctrl.subtract  = !zone_offset[cte_pkg::ZONE_W-1];
            ctrl.count     = zone_offset[cte_pkg::ZONE_W-1] ? (~zone_offset + 11'd1)
                                                            : zone_offset;
         end
         cte_pkg::ST_DRAIN: begin
         end
         cte_pkg::ST_FINISH: begin
            status.load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   // Loop counters
   always_comb begin
      yidx_in = yidx_ff;
      midx_in = midx_ff;
      err_in  = err_ff;
      if (accept) begin
         yidx_in = '0;
         midx_in = 4'd1;
         err_in  = in_bad;
      end else if (state_ff == cte_pkg::ST_YEAR && year_more) begin
         yidx_in = yidx_ff + 8'd1;
      end else if (state_ff == cte_pkg::ST_MONTH && month_more) begin
         midx_in = midx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cte_pkg::ST_IDLE;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
      yidx_ff <= yidx_in;
      midx_ff <= midx_in;
      if (accept) begin
         year_ff   <= year_of_century;
         month_ff  <= month_number;
         day_ff    <= day_of_month;
         hour_ff   <= hour_of_day;
         minute_ff <= minute_of_hour;
         second_ff <= second_of_minute;
      end
   end

endmodule

@@ sv/calendar_to_epoch_timestamp_unit.sv @@
// Calendar time (years 2000..2099) to Unix timestamp in seconds or milliseconds.
// req_ch carries one calendar time per transaction; rsp_ch returns one result
// with timestamp and field_error for each. csr_ch writes index 0 (unit_millis)
// and index 1 (zone_offset_minutes, signed, subtracted from the result).
// One shared multiply-accumulate unit adds one term per cycle: one per year
// since 1970, one per month before the given one, then day, hour, minute,
// second and zone. A valid transaction steps through the year loop, the
// month loop, then day, hour, minute, second, zone and drain before its
// result loads; a transaction with an out-of-range field goes straight to
// the finish state with field_error set and a zero timestamp. One transaction
// is in work at a time; req ready is high only while the sequencer is idle,
// so the next transaction is taken at the earliest in the cycle after a result loads.
// The result sits in an output register; while the receiver stalls it holds
// there and the next transaction may already be accepted and computed, but it
// finishes only once the register frees.
// Reset (synchronous, active high) empties the output register, returns the
// sequencer to idle and restores unit_millis = 1 and zone offset = 0.
// Configuration writes are always accepted and should be made while idle.
`include "calendar_to_epoch_timestamp_unit_defines.svh"

module calendar_to_epoch_timestamp_unit (
   input  logic       clock,
   input  logic       reset,
   cte_req_if.sink    req_ch,
   cte_rsp_if.source  rsp_ch,
   cte_csr_if.sink    csr_ch
);

   logic                            unit_millis_ff, unit_millis_in;
   logic [cte_pkg::ZONE_W-1:0]      zone_ff, zone_in;
   logic                            out_valid_ff, out_valid_in;
   logic [cte_pkg::TS_W-1:0]        out_ts_ff, out_ts_in;
   logic                            out_err_ff, out_err_in;

   logic                            csr_write;
   logic                            out_free;
   logic [cte_pkg::TS_W-1:0]        acc;
   cte_pkg::alu_ctrl_type           ctrl;
   cte_pkg::seq_status_type         status;

   // Configuration registers
   always_comb begin
      csr_write      = csr_ch.valid && csr_ch.ready;
      unit_millis_in = unit_millis_ff;
      zone_in        = zone_ff;
      if (csr_write && csr_ch.index == cte_pkg::CSR_UNIT_MILLIS) begin
         unit_millis_in = csr_ch.data[0];
      end
      if (csr_write && csr_ch.index == cte_pkg::CSR_ZONE_OFFSET) begin
         zone_in = csr_ch.data;
      end
   end

   assign csr_ch.ready = 1'b1;

   cte_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .year_of_century  (req_ch.year_of_century),
      .month_number     (req_ch.month_number),
      .day_of_month     (req_ch.day_of_month),
      .hour_of_day      (req_ch.hour_of_day),
      .minute_of_hour   (req_ch.minute_of_hour),
      .second_of_minute (req_ch.second_of_minute),
      .zone_offset      (zone_ff),
      .out_free         (out_free),
      .ctrl             (ctrl),
      .status           (status)
   );

   cte_alu u_alu (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .unit_millis (unit_millis_ff),
      .acc         (acc)
   );

   assign req_ch.ready = status.req_ready;

   // Output register
   always_comb begin
      out_free     = !out_valid_ff || rsp_ch.ready;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_ts_in    = out_ts_ff;
      out_err_in   = out_err_ff;
      if (status.load_out) begin
         out_valid_in = 1'b1;
         out_ts_in    = status.field_error ? '0 : acc;
         out_err_in   = status.field_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_millis_ff <= 1'b1;
         zone_ff        <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         unit_millis_ff <= unit_millis_in;
         zone_ff        <= zone_in;
         out_valid_ff   <= out_valid_in;
      end
      out_ts_ff  <= out_ts_in;
      out_err_ff <= out_err_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.timestamp   = out_ts_ff;
   assign rsp_ch.field_error = out_err_ff;

   // An error result never carries a timestamp
   `CTE_ASSERT_SAME(a_err_zero_ts, clock, reset, out_valid_ff && out_err_ff, out_ts_ff == '0)
   // The sequencer stops taking transactions once one is accepted
   `CTE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   // A unit write lands in the register
   `CTE_ASSERT_NEXT(a_unit_write, clock, reset,
      csr_ch.valid && csr_ch.ready && csr_ch.index == cte_pkg::CSR_UNIT_MILLIS,
      unit_millis_ff == $past(csr_ch.data[0]))

endmodule

@@ test/cte_timestamp_checker.sv @@
module cte_timestamp_checker (
   input  logic clock,
   input  logic reset,
   cte_req_if   req_mon,
   cte_rsp_if   rsp_mon,
   cte_csr_if   csr_mon,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count,
   output int   flagged_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import cte_pkg::*;

   typedef struct packed {
      logic [TS_W-1:0] timestamp;
      logic            field_error;
   } epoch_stamp_type;

   // Month lengths of a common year, January first
   localparam int unsigned COMMON_MONTH_DAYS [12] =
      '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   logic                     unit_millis;
   logic signed [ZONE_W-1:0] zone_offset;
   epoch_stamp_type          expected_stamps [$];

   // Gregorian rule: every fourth year, centuries only when divisible by 400
   function automatic bit is_leap(input int unsigned year);
      return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
   endfunction

   function automatic int unsigned month_length(input int unsigned month, input bit leap_year);
      return COMMON_MONTH_DAYS[month - 1] + ((month == 2 && leap_year) ? 1 : 0);
   endfunction

   // Calendar time to seconds or milliseconds since 1970, less the zone offset
   function automatic epoch_stamp_type convert_to_epoch(
      input logic [YEAR_W-1:0]      yc,
      input logic [MONTH_W-1:0]     mo,
      input logic [DAY_W-1:0]       dd,
      input logic [HOUR_W-1:0]      hh,
      input logic [MINUTE_W-1:0]    mi,
      input logic [SECOND_W-1:0]    ss,
      input logic                   millis,
      input logic signed [ZONE_W-1:0] zone
   );
      epoch_stamp_type stamp;
      int unsigned  year;
      int unsigned  y;
      int unsigned  m;
      longint       days;
      longint       secs;
      longint       offset;
      longint       total;
      stamp.timestamp   = '0;
      stamp.field_error = 1'b1;
      year = 2000 + int'(yc);
      if (yc > 99 || mo == 0 || mo > 12 || hh > 23 || mi > 59 || ss > 59 || dd == 0)
         return stamp;
      if (int'(dd) > month_length(mo, is_leap(year)))
         return stamp;
      days = 0;
      for (y = 1970; y < year; y++)
         days += is_leap(y) ? 366 : 365;
      for (m = 1; m < mo; m++)
         days += month_length(m, is_leap(year));
      days += longint'(dd) - 1;
      secs = days * 86400 + longint'(hh) * 3600 + longint'(mi) * 60 + longint'(ss);
      offset = longint'(zone);
      if (millis)
         total = secs * 1000 - offset * 60000;
      else
         total = secs - offset * 60;
      stamp.timestamp   = total[TS_W-1:0];
      stamp.field_error = 1'b0;
      return stamp;
   endfunction

   // Track register writes, check results, queue predictions
   always @(posedge clock) begin
      epoch_stamp_type seen;
      epoch_stamp_type want;
      if (reset) begin
         unit_millis = 1'b1;
         zone_offset = '0;
         expected_stamps.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_UNIT_MILLIS)
               unit_millis = csr_mon.data[0];
            else if (csr_mon.index == CSR_ZONE_OFFSET)
               zone_offset = csr_mon.data[ZONE_W-1:0];
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.timestamp   = rsp_mon.timestamp;
            seen.field_error = rsp_mon.field_error;
            if (expected_stamps.size() == 0) begin
               $error("unexpected result transaction: timestamp %0d, field_error %0b",
                      seen.timestamp, seen.field_error);
               fail_count++;
            end else begin
               want = expected_stamps.pop_front();
               checked_count++;
               if (want.field_error)
                  flagged_count++;
               if (seen.timestamp !== want.timestamp) begin
                  $error("timestamp: expected %0d, actual %0d", want.timestamp, seen.timestamp);
                  fail_count++;
               end
               if (seen.field_error !== want.field_error) begin
                  $error("field_error: expected %0b, actual %0b",
                         want.field_error, seen.field_error);
                  fail_count++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready)
            expected_stamps.push_back(convert_to_epoch(
               req_mon.year_of_century, req_mon.month_number, req_mon.day_of_month,
               req_mon.hour_of_day, req_mon.minute_of_hour, req_mon.second_of_minute,
               unit_millis, zone_offset));
      end
      pending_count = expected_stamps.size();
   end

endmodule

@@ test/tb_calendar_to_epoch_timestamp_unit.sv @@
module tb_calendar_to_epoch_timestamp_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import cte_pkg::*;

   localparam int     CLOCK_HALF       = 5;
   localparam int     RESET_CYCLES     = 9;
   localparam int     RANDOM_PER_PHASE = 200;
   localparam int     LONG_HOLD_CYCLES = 400;
   localparam int     DRAIN_SETTLE     = 4;
   localparam int     END_CYCLES       = 200;
   localparam longint RUN_LIMIT_NS     = 10_000_000;

   // Indexes outside the register list; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   // Per-phase handshake mix and register setting
   localparam int NUM_PHASES = 4;
   localparam int PHASE_IDLE   [NUM_PHASES] = '{0, 76, 0, 34};
   localparam int PHASE_STALL  [NUM_PHASES] = '{0, 0, 76, 34};
   localparam int PHASE_MILLIS [NUM_PHASES] = '{0, 1, 0, 1};
   localparam int PHASE_ZONE   [NUM_PHASES] = '{-720, 840, 1023, -1024};

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } cal_time_type;

   localparam int CAL_W = $bits(cal_time_type);

   typedef enum int {
      BREAK_YEAR,
      BREAK_MONTH,
      BREAK_DAY,
      BREAK_HOUR,
      BREAK_MINUTE,
      BREAK_SECOND
   } broken_field_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   checked_count;
   int   flagged_count;
   int   req_idle_pct  = 0;
   int   rsp_stall_pct = 0;
   int   hold_requests = 0;
   int   settings_used = 0;

   cte_req_if req_ch ();
   cte_rsp_if rsp_ch ();
   cte_csr_if csr_ch ();

   calendar_to_epoch_timestamp_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cte_timestamp_checker stamp_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_mon       (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .flagged_count (flagged_count)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   // Result receiver: random stalls, plus long holds on request
   initial begin
      int hold_served;
      hold_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_served != hold_requests) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_served++;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("** calendar_to_epoch_timestamp_unit: FAILED **");
      $finish;
   end

   function automatic cal_time_type make_time(input int y, input int mo, input int d,
                                              input int h, input int mi, input int s);
      cal_time_type t;
      t.year   = YEAR_W'(y);
      t.month  = MONTH_W'(mo);
      t.day    = DAY_W'(d);
      t.hour   = HOUR_W'(h);
      t.minute = MINUTE_W'(mi);
      t.second = SECOND_W'(s);
      return t;
   endfunction

   // Offer one transaction after an optional random gap; valid stays high on return
   task automatic drive_time(input cal_time_type t);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.year_of_century  <= t.year;
      req_ch.month_number     <= t.month;
      req_ch.day_of_month     <= t.day;
      req_ch.hour_of_day      <= t.hour;
      req_ch.minute_of_hour   <= t.minute;
      req_ch.second_of_minute <= t.second;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering and wait for every outstanding result
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   // Mostly well-formed dates, some with one field broken, some raw noise
   task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                   input bit long_hold, input bit drain_pause);
      cal_time_type     t;
      broken_field_type which;
      int               kind;
      req_idle_pct  <= idle_pct;
      rsp_stall_pct <= stall_pct;
      if (long_hold)
         hold_requests <= hold_requests + 1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         if (drain_pause && i == RANDOM_PER_PHASE / 2)
            wait_for_drain();
         kind = $urandom_range(99);
         if (kind < 93) begin
            t.year   = YEAR_W'($urandom_range(99));
            t.month  = MONTH_W'($urandom_range(12, 1));
            t.day    = ($urandom_range(99) < 75) ? DAY_W'($urandom_range(28, 1))
                                                 : DAY_W'($urandom_range(31, 29));
            t.hour   = HOUR_W'($urandom_range(23));
            t.minute = MINUTE_W'($urandom_range(59));
            t.second = SECOND_W'($urandom_range(59));
            if (kind >= 80) begin
               which = broken_field_type'($urandom_range(BREAK_SECOND));
               case (which)
                  BREAK_YEAR:   t.year   = YEAR_W'($urandom_range(127, 100));
                  BREAK_MONTH:  t.month  = $urandom_range(1) ? '0
                                           : MONTH_W'($urandom_range(15, 13));
                  BREAK_DAY:    t.day    = '0;
                  BREAK_HOUR:   t.hour   = HOUR_W'($urandom_range(31, 24));
                  BREAK_MINUTE: t.minute = MINUTE_W'($urandom_range(63, 60));
                  default:      t.second = SECOND_W'($urandom_range(63, 60));
               endcase
            end
         end else begin
            t = CAL_W'({$urandom, $urandom});
         end
         drive_time(t);
      end
      req_ch.valid <= 1'b0;
   endtask

   // Stimulus
   initial begin
      cal_time_type directed_times [$];

      req_ch.valid            <= 1'b0;
      req_ch.year_of_century  <= '0;
      req_ch.month_number     <= '0;
      req_ch.day_of_month     <= '0;
      req_ch.hour_of_day      <= '0;
      req_ch.minute_of_hour   <= '0;
      req_ch.second_of_minute <= '0;
      csr_ch.valid            <= 1'b0;
      csr_ch.index            <= '0;
      csr_ch.data             <= '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_UNIT_MILLIS, CSR_DATA_W'(1));
      write_csr(CSR_ZONE_OFFSET, '0);
      settings_used++;

      // Range ends, leap-day rules, and every out-of-range field
      directed_times.push_back(make_time(0, 1, 1, 0, 0, 0));
      directed_times.push_back(make_time(99, 12, 31, 23, 59, 59));
      directed_times.push_back(make_time(0, 2, 29, 12, 0, 0));
      directed_times.push_back(make_time(4, 2, 29, 6, 30, 15));
      directed_times.push_back(make_time(96, 2, 29, 23, 59, 59));
      directed_times.push_back(make_time(1, 2, 29, 0, 0, 0));
      directed_times.push_back(make_time(99, 2, 29, 0, 0, 0));
      directed_times.push_back(make_time(24, 4, 31, 0, 0, 0));
      directed_times.push_back(make_time(24, 4, 30, 0, 0, 0));
      directed_times.push_back(make_time(24, 0, 1, 0, 0, 0));
      directed_times.push_back(make_time(24, 13, 1, 0, 0, 0));
      directed_times.push_back(make_time(24, 15, 31, 31, 63, 63));
      directed_times.push_back(make_time(24, 6, 0, 8, 0, 0));
      directed_times.push_back(make_time(100, 1, 1, 0, 0, 0));
      directed_times.push_back(make_time(127, 15, 31, 31, 63, 63));
      directed_times.push_back(make_time(50, 7, 15, 24, 0, 0));
      directed_times.push_back(make_time(50, 7, 15, 0, 60, 0));
      directed_times.push_back(make_time(50, 7, 15, 0, 0, 60));
      directed_times.push_back(make_time(0, 0, 0, 0, 0, 0));
      directed_times.push_back(make_time(38, 1, 19, 3, 14, 7));
      directed_times.push_back(make_time(24, 3, 1, 12, 34, 56));
      directed_times.push_back(make_time(99, 1, 1, 0, 0, 0));
      foreach (directed_times[i])
         drive_time(directed_times[i]);
      wait_for_drain();

      // Random phases, each under its own unit and zone setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(CSR_UNIT_MILLIS, CSR_DATA_W'(PHASE_MILLIS[p]));
         write_csr(CSR_ZONE_OFFSET, CSR_DATA_W'(PHASE_ZONE[p]));
         if (p == 2)
            write_csr(CSR_SPARE_2, CSR_DATA_W'($urandom));
         if (p == 3)
            write_csr(CSR_SPARE_3, CSR_DATA_W'($urandom));
         settings_used++;
         run_random_phase(PHASE_IDLE[p], PHASE_STALL[p], p == 0, p == 2);
         wait_for_drain();
      end

      // Catch any stray result after the last one
      repeat (END_CYCLES) @(posedge clock);

      $display("Checked %0d conversions (%0d flagged out of range) under %0d unit/zone settings,",
               checked_count, flagged_count, settings_used);
      $display("with free flow, sparse sender, stalling receiver, mixed gaps and a long hold.");
      if (fail_count == 0 && pending_count == 0)
         $display("** calendar_to_epoch_timestamp_unit: PASSED **");
      else
         $display("** calendar_to_epoch_timestamp_unit: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/cte_pkg.sv
sv/cte_ifs.sv
sv/cte_alu.sv
sv/cte_seq.sv
sv/calendar_to_epoch_timestamp_unit.sv
test/cte_timestamp_checker.sv
test/tb_calendar_to_epoch_timestamp_unit.sv
